>>> rtl/kmc_pkg.sv
// Shared constants for the one-dimensional k-means clustering core.
// No dependencies.
`timescale 1ns / 1ps
package kmc_pkg;
	localparam int MAX_POINTS_DEF  = 64;
	localparam int MAX_CLASSES_DEF = 16;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FRAC_BITS       = 8;

	// Configuration register map.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_CLASSES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PASSES  = 1'd1;
	localparam logic [4:0] NUM_CLASSES_RST = 5'd2;
	localparam logic [7:0] MAX_PASSES_RST  = 8'd100;
endpackage

>>> rtl/kmc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module kmc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/kmc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies; used by the clustering core for seeds and means.
`timescale 1ns / 1ps
module kmc_div #(
	parameter int DW = 34,
	parameter int VW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int CNTW = $clog2(DW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   quo_q;
	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   div_q;
	logic [VW:0]     trial;
	logic            fits;

	// One shift-and-subtract step.
	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		fits  = (trial >= {1'b0, div_q});
	end

	// Control: count down the quotient bits, pulse done after the last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? VW'(trial - {1'b0, div_q}) : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

>>> rtl/kmeans_1d_clustering_core.sv
// Top level of the one-dimensional k-means clustering core.
// Depends on kmc_pkg, kmc_ram and kmc_div.
//
//   port group    direction  handshake          beat
//   in_*          in         in_valid/in_ready  one sample and its last flag
//   out_*         out        out_valid/out_ready one class result per sample
//   cfg_*         in         cfg_write_en       one register write
//
// Samples load at one beat per cycle into the sample memory.
// After the last sample of a set, clustering runs with input held off: every
// sample is marked unassigned, the centres are seeded, and each pass assigns
// every sample to its nearest centre and then updates the means; seeds and
// means both come from the shared serial divider.
// Results then leave one beat at a time, each after its class memory read.
// Reset clears all control state; memory contents are not cleared.
// A stalled output beat holds its register until it is taken.
`timescale 1ns / 1ps
module kmeans_1d_clustering_core
	import kmc_pkg::*;
#(
	parameter int MAX_POINTS  = MAX_POINTS_DEF,
	parameter int MAX_CLASSES = MAX_CLASSES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_BITS-1:0]  sample_value,
	input  logic                           last_sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [$clog2(MAX_POINTS)-1:0]  point_index,
	output logic [$clog2(MAX_CLASSES)-1:0] class_index,
	output logic                           last_point,
	input  logic                           cfg_write_en,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [CFG_DATA_W-1:0]          cfg_data
);
	localparam int SB   = SAMPLE_BITS;
	localparam int LP   = $clog2(MAX_POINTS);
	localparam int LC   = $clog2(MAX_CLASSES);
	localparam int CW   = SB + FRAC_BITS + 1;
	localparam int DSTW = CW + 1;
	localparam int SUMW = SB + LP + 1;
	localparam int SPW  = SB + 1;
	localparam int DW   = (LP > LC + 1) ? SUMW + FRAC_BITS : SB + LC + FRAC_BITS + 2;
	localparam int VW   = (LP + 1 > LC + 2) ? LP + 1 : LC + 2;

	localparam logic [3:0] S_LOAD = 4'd0;
	localparam logic [3:0] S_INIT = 4'd1;
	localparam logic [3:0] S_DIV  = 4'd2;
	localparam logic [3:0] S_DIVW = 4'd3;
	localparam logic [3:0] S_PCLR = 4'd4;
	localparam logic [3:0] S_RD   = 4'd5;
	localparam logic [3:0] S_CMP  = 4'd6;
	localparam logic [3:0] S_ACC  = 4'd7;
	localparam logic [3:0] S_ERD  = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	logic [3:0]               state_q;
	logic [4:0]               num_classes_q;
	logic [7:0]               max_passes_q;
	logic [LP:0]              cnt_q;
	logic [LP:0]              n_q;
	logic [LP:0]              j_q;
	logic [LC:0]              k_q;
	logic [LC:0]              i_q;
	logic [7:0]               passes_q;
	logic [7:0]               pass_q;
	logic [LP:0]              changed_q;
	logic                     seeding_q;
	logic                     mean_q;
	logic                     neg_q;
	logic signed [SB-1:0]     low_q;
	logic signed [SB-1:0]     high_q;
	logic signed [CW-1:0]     centre_q [MAX_CLASSES];
	logic signed [SUMW-1:0]   sum_q [MAX_CLASSES];
	logic [LP:0]              count_q [MAX_CLASSES];
	logic [DSTW-1:0]          best_d_q;
	logic [LC-1:0]            best_q;
	logic [LP-1:0]            out_idx_q;
	logic                     out_last_q;
	logic                     out_valid_q;

	logic                     in_beat;
	logic                     smp_we;
	logic signed [SB-1:0]     smp_rdata;
	logic                     cls_we;
	logic [LC:0]              cls_wdata;
	logic [LC:0]              cls_rdata;
	logic                     div_start;
	logic                     div_done;
	logic [DW-1:0]            div_dividend;
	logic [VW-1:0]            div_divisor;
	logic [DW-1:0]            div_q;
	logic [LC-1:0]            ci;
	logic [SPW-1:0]           span;
	logic [DW-1:0]            seed_num;
	logic [SUMW-1:0]          sum_mag;
	logic signed [CW-1:0]     scaled;
	logic signed [DSTW-1:0]   diff;
	logic [DSTW-1:0]          dist_abs;
	logic signed [CW-1:0]     low256;
	logic [CW-1:0]            qc;
	logic [4:0]               k_sat;

	assign ci      = i_q[LC-1:0];
	assign in_beat = in_valid && in_ready;
	assign in_ready = (state_q == S_LOAD);

	// Sample and class memories.
	assign smp_we = in_beat;
	kmc_ram #(.WIDTH(SB), .DEPTH(MAX_POINTS)) u_smp (
		.clk(clk), .we(smp_we), .waddr(cnt_q[LP-1:0]), .wdata(sample_value),
		.raddr(j_q[LP-1:0]), .rdata(smp_rdata)
	);

	assign cls_we    = (state_q == S_INIT) || (state_q == S_ACC);
	assign cls_wdata = (state_q == S_INIT) ? k_q : {1'b0, best_q};
	kmc_ram #(.WIDTH(LC + 1), .DEPTH(MAX_POINTS)) u_cls (
		.clk(clk), .we(cls_we), .waddr(j_q[LP-1:0]), .wdata(cls_wdata),
		.raddr(j_q[LP-1:0]), .rdata(cls_rdata)
	);

	// Divider operands: a seed offset or a class mean.
	always_comb begin
		span     = SPW'({high_q[SB-1], high_q} - {low_q[SB-1], low_q});
		seed_num = (DW'({i_q, 1'b1}) * DW'(span)) << FRAC_BITS;
		sum_mag  = sum_q[ci][SUMW-1] ? SUMW'(-sum_q[ci]) : SUMW'(sum_q[ci]);
		low256   = {low_q[SB-1], low_q, {FRAC_BITS{1'b0}}};
		qc       = div_q[CW-1:0];
		if (!seeding_q && count_q[ci] != '0) begin
			div_dividend = DW'({sum_mag, {FRAC_BITS{1'b0}}});
			div_divisor  = VW'(count_q[ci]);
		end else begin
			div_dividend = seed_num;
			div_divisor  = VW'({k_q, 1'b0});
		end
	end
	assign div_start = (state_q == S_DIV);

	kmc_div #(.DW(DW), .VW(VW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(div_divisor), .done(div_done), .quotient(div_q)
	);

	// Distance from the current sample to the centre under test.
	always_comb begin
		scaled   = {smp_rdata[SB-1], smp_rdata, {FRAC_BITS{1'b0}}};
		diff     = DSTW'(scaled) - DSTW'(centre_q[ci]);
		dist_abs = diff[DSTW-1] ? DSTW'(-diff) : DSTW'(diff);
	end

	// Class count as latched at the close of a set.
	always_comb begin
		if (num_classes_q == 5'd0) begin
			k_sat = 5'd1;
		end else if (num_classes_q > 5'(MAX_CLASSES)) begin
			k_sat = 5'(MAX_CLASSES);
		end else begin
			k_sat = num_classes_q;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q <= NUM_CLASSES_RST;
			max_passes_q  <= MAX_PASSES_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_NUM_CLASSES: num_classes_q <= cfg_data[4:0];
				REG_MAX_PASSES:  max_passes_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer: load, seed, passes of assignment and update, emission.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			n_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			i_q         <= '0;
			passes_q    <= '0;
			pass_q      <= '0;
			changed_q   <= '0;
			seeding_q   <= 1'b0;
			low_q       <= '0;
			high_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_beat) begin
						if (cnt_q == '0 || sample_value < low_q) low_q <= sample_value;
						if (cnt_q == '0 || sample_value > high_q) high_q <= sample_value;
						cnt_q <= cnt_q + 1'b1;
						if (last_sample || cnt_q == (LP + 1)'(MAX_POINTS - 1)) begin
							n_q      <= cnt_q + 1'b1;
							k_q      <= (LC + 1)'(k_sat);
							passes_q <= (max_passes_q == 8'd0) ? 8'd1 : max_passes_q;
							j_q      <= '0;
							state_q  <= S_INIT;
						end
					end
				end
				S_INIT: begin
					j_q <= j_q + 1'b1;
					if (j_q + 1'b1 == n_q) begin
						i_q       <= '0;
						seeding_q <= 1'b1;
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_done) begin
						i_q <= i_q + 1'b1;
						if (i_q + 1'b1 != k_q) begin
							state_q <= S_DIV;
						end else if (seeding_q) begin
							seeding_q <= 1'b0;
							pass_q    <= '0;
							state_q   <= S_PCLR;
						end else if (changed_q == '0 || pass_q + 8'd1 == passes_q) begin
							j_q     <= '0;
							state_q <= S_ERD;
						end else begin
							pass_q  <= pass_q + 8'd1;
							state_q <= S_PCLR;
						end
					end
				end
				S_PCLR: begin
					changed_q <= '0;
					j_q       <= '0;
					state_q   <= S_RD;
				end
				S_RD: begin
					i_q     <= '0;
					state_q <= S_CMP;
				end
				S_CMP: begin
					i_q <= i_q + 1'b1;
					if (i_q + 1'b1 == k_q) state_q <= S_ACC;
				end
				S_ACC: begin
					if (cls_rdata != {1'b0, best_q}) changed_q <= changed_q + 1'b1;
					j_q <= j_q + 1'b1;
					if (j_q + 1'b1 == n_q) begin
						i_q     <= '0;
						state_q <= S_DIV;
					end else begin
						state_q <= S_RD;
					end
				end
				S_ERD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							cnt_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// Nearest-centre search, class accumulators and centre updates.
	always_ff @(posedge clk) begin
		if (state_q == S_PCLR) begin
			for (int c = 0; c < MAX_CLASSES; c++) begin
				sum_q[c]   <= '0;
				count_q[c] <= '0;
			end
		end
		if (state_q == S_CMP && (i_q == '0 || dist_abs < best_d_q)) begin
			best_d_q <= dist_abs;
			best_q   <= ci;
		end
		if (state_q == S_ACC) begin
			sum_q[best_q]   <= sum_q[best_q] + SUMW'(smp_rdata);
			count_q[best_q] <= count_q[best_q] + 1'b1;
		end
		if (state_q == S_DIV) begin
			mean_q <= !seeding_q && count_q[ci] != '0;
			neg_q  <= sum_q[ci][SUMW-1];
		end
		if (state_q == S_DIVW && div_done) begin
			if (mean_q) begin
				centre_q[ci] <= neg_q ? CW'(-qc) : CW'(qc);
			end else begin
				centre_q[ci] <= low256 + CW'(qc);
			end
		end
		if (state_q == S_ERD) begin
			out_idx_q  <= j_q[LP-1:0];
			out_last_q <= (j_q + 1'b1 == n_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign point_index = out_idx_q;
	assign class_index = cls_rdata[LC-1:0];
	assign last_point  = out_last_q;
endmodule

>>> rtl/kmc_chk.sv
// Port-level checker for the clustering core, bound to the top level.
// Depends on kmeans_1d_clustering_core only through the bind below.
`timescale 1ns / 1ps
module kmc_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic last_point
);
	// Loading and emission never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !out_valid)
		else $error("input beat taken while a result is pending");

	// Input stays closed while a set is still being emitted.
	a_emit_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_point) |=> !in_ready)
		else $error("input opened before the last result");

	// The final result ends emission.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_point) |=> !out_valid)
		else $error("result shown after the last beat");

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result withdrawn while stalled");
endmodule

bind kmeans_1d_clustering_core kmc_chk u_kmc_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .last_point(last_point)
);
